// ===== design/dmm_pkg.sv =====
`default_nettype none

package dmm_pkg;

   localparam int IDX_IN_W  = 4;
   localparam int DIM_CFG_W = 5;
   localparam int VALUE_W   = 32;
   localparam int SUM_W     = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_CFG_W-1:0] DIM_RESET = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   typedef enum logic [1:0] {
      CMD_WRITE_A = 2'd0,
      CMD_WRITE_B = 2'd1,
      CMD_COMPUTE = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT_MUL,
      ST_WAIT_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic [IDX_IN_W-1:0]        row_idx;
      logic [IDX_IN_W-1:0]        col_idx;
      logic signed [VALUE_W-1:0]  elem_value;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] dot_sum;
      logic                    index_error;
   } rsp_type;

   typedef struct packed {
      logic [DIM_CFG_W-1:0] rows_a;
      logic [DIM_CFG_W-1:0] inner_len;
      logic [DIM_CFG_W-1:0] cols_b;
   } dims_type;

   typedef struct packed {
      logic we_a;
      logic we_b;
      logic issue;
      logic clear;
   } dp_ctl_type;

   typedef struct packed {
      logic load;
      logic index_error;
   } rsp_ctl_type;

endpackage

`default_nettype wire

// ===== design/dmm_store.sv =====
`default_nettype none

module dmm_store #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 8
) (
   input  wire                        clock,
   input  dmm_pkg::dp_ctl_type        dp_ctl,
   input  wire  [ADDR_W-1:0]          wr_addr,
   input  wire  [DATA_W-1:0]          wr_data,
   input  wire  [ADDR_W-1:0]          rd_addr_a,
   input  wire  [ADDR_W-1:0]          rd_addr_b,
   output logic [DATA_W-1:0]          a_rd_ff,
   output logic [DATA_W-1:0]          b_rd_ff
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] a_mem [DEPTH];
   logic [DATA_W-1:0] b_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (dp_ctl.we_a) begin
         a_mem[wr_addr] <= wr_data;
      end
      if (dp_ctl.issue) begin
         a_rd_ff <= a_mem[rd_addr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_ctl.we_b) begin
         b_mem[wr_addr] <= wr_data;
      end
      if (dp_ctl.issue) begin
         b_rd_ff <= b_mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// ===== design/dmm_mac.sv =====
`default_nettype none

module dmm_mac #(
   parameter int DATA_W = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  dmm_pkg::dp_ctl_type   dp_ctl,
   input  wire  [DATA_W-1:0]     a_rd,
   input  wire  [DATA_W-1:0]     b_rd,
   output logic [DATA_W-1:0]     acc_ff
);

   logic                  rd_vld_ff;
   logic                  prod_vld_ff;
   logic [DATA_W-1:0]     prod_ff;
   logic [DATA_W-1:0]     prod_low;
   logic [DATA_W-1:0]     acc_in;

   // Only the low half of the product matters: everything wraps at DATA_W bits.
   assign prod_low = a_rd * b_rd;

   always_comb begin
      acc_in = acc_ff;
      if (dp_ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= dp_ctl.issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_ff <= prod_low;
      end
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

// ===== design/dmm_ctrl.sv =====
`default_nettype none

module dmm_ctrl #(
   parameter int MAX_DIM = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  dmm_pkg::req_type             req_data,
   output logic                         req_stall,
   input  dmm_pkg::dims_type            dims,
   input  wire                          rsp_free,
   output dmm_pkg::rsp_ctl_type         rsp_ctl,
   output dmm_pkg::dp_ctl_type          dp_ctl,
   output logic [2*$clog2(MAX_DIM)-1:0] wr_addr,
   output logic [2*$clog2(MAX_DIM)-1:0] rd_addr_a,
   output logic [2*$clog2(MAX_DIM)-1:0] rd_addr_b
);

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W = (DIM_W > dmm_pkg::DIM_CFG_W) ? DIM_W : dmm_pkg::DIM_CFG_W;
   localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

   dmm_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [IDX_W-1:0]   row_ff, col_ff;
   logic               err_ff;

   logic [CMP_W-1:0]   m_eff, kd_eff, n_eff;
   logic [CMP_W-1:0]   row_c, col_c;
   logic [IDX_W-1:0]   row_n, col_n;
   logic               accept;
   logic               err_in;
   logic               k_last;

   // Dimension registers above MAX_DIM saturate to it.
   always_comb begin
      m_eff  = (CMP_W'(dims.rows_a) > MAX_DIM_C) ? MAX_DIM_C : CMP_W'(dims.rows_a);
      kd_eff = (CMP_W'(dims.inner_len) > MAX_DIM_C) ? MAX_DIM_C : CMP_W'(dims.inner_len);
      n_eff  = (CMP_W'(dims.cols_b) > MAX_DIM_C) ? MAX_DIM_C : CMP_W'(dims.cols_b);
   end

   assign row_c    = CMP_W'(req_data.row_idx);
   assign col_c    = CMP_W'(req_data.col_idx);
   assign row_n    = IDX_W'(req_data.row_idx);
   assign col_n    = IDX_W'(req_data.col_idx);

   always_comb begin
      case (req_data.cmd)
         dmm_pkg::CMD_WRITE_A: err_in = !(row_c < m_eff && col_c < kd_eff);
         dmm_pkg::CMD_WRITE_B: err_in = !(row_c < kd_eff && col_c < n_eff);
         default:              err_in = !(row_c < m_eff && col_c < n_eff);
      endcase
   end

   assign req_stall = (state_ff != dmm_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign k_last    = ((CMP_W'(k_ff) + CMP_W'(1)) == kd_eff);

   assign wr_addr   = {row_n, col_n};
   assign rd_addr_a = {row_ff, k_ff};
   assign rd_addr_b = {k_ff, col_ff};

   always_comb begin
      state_in            = state_ff;
      k_in                = k_ff;
      dp_ctl              = '0;
      rsp_ctl.load        = 1'b0;
      rsp_ctl.index_error = err_ff;
      unique case (state_ff)
         dmm_pkg::ST_IDLE: begin
            k_in = '0;
            if (accept) begin
               dp_ctl.clear = 1'b1;
               unique case (req_data.cmd)
                  dmm_pkg::CMD_WRITE_A: begin
                     dp_ctl.we_a = !err_in;
                     state_in    = dmm_pkg::ST_DONE;
                  end
                  dmm_pkg::CMD_WRITE_B: begin
                     dp_ctl.we_b = !err_in;
                     state_in    = dmm_pkg::ST_DONE;
                  end
                  dmm_pkg::CMD_COMPUTE: begin
                     // An error or an empty inner dimension leaves the cleared sum.
                     if (err_in || kd_eff == '0) begin
                        state_in = dmm_pkg::ST_DONE;
                     end else begin
                        state_in = dmm_pkg::ST_RUN;
                     end
                  end
                  default: begin
                     state_in = dmm_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         dmm_pkg::ST_RUN: begin
            dp_ctl.issue = 1'b1;
            k_in         = k_ff + IDX_W'(1);
            if (k_last) begin
               state_in = dmm_pkg::ST_WAIT_MUL;
            end
         end
         dmm_pkg::ST_WAIT_MUL: begin
            state_in = dmm_pkg::ST_WAIT_ACC;
         end
         dmm_pkg::ST_WAIT_ACC: begin
            state_in = dmm_pkg::ST_DONE;
         end
         dmm_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_ctl.load = 1'b1;
               state_in     = dmm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmm_pkg::ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff <= row_n;
         col_ff <= col_n;
         err_ff <= err_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/dense_matrix_multiply_core.sv =====
`default_nettype none

// Channel   Direction  Handshake           Carries
// req_      in         req_valid/req_stall  cmd, row_idx, col_idx, elem_value
// rsp_      out        rsp_valid/rsp_stall  dot_sum, index_error
// csr_      in         csr_valid/csr_ready  register index and 5-bit dimension
//
// A write item goes from idle straight to the done state; a compute item issues
// one read per inner index, K being the effective inner dimension, since A and B
// stores each give one element per cycle to a single multiply-accumulate unit. A
// compute with an index error or with K of zero reads nothing and goes to done, like a write.
// A command code of 3 is dropped in its accept cycle and gives no transfer.
// Reset is synchronous; it clears control state and sets all dimensions to 16.
// The finished result sits in an output register, so the next item is accepted
// while rsp_stall holds it.

module dense_matrix_multiply_core #(
   parameter int MAX_DIM   = 16,
   parameter int ELEM_BITS = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  dmm_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output dmm_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [dmm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [dmm_pkg::DIM_CFG_W-1:0]        csr_wdata
);

   // Sums wrap at the smaller of ELEM_BITS and 32 bits, the width of the result.
   localparam int DATA_W = (ELEM_BITS < dmm_pkg::SUM_W) ? ELEM_BITS : dmm_pkg::SUM_W;
   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = 2 * IDX_W;

   dmm_pkg::dims_type     dims_ff, dims_in;
   dmm_pkg::rsp_ctl_type  rsp_ctl;
   dmm_pkg::dp_ctl_type   dp_ctl;
   dmm_pkg::rsp_type      rsp_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     wr_addr, rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0]     a_rd, b_rd, acc;
   logic [dmm_pkg::SUM_W-1:0] sum_out;

   assign csr_ready = 1'b1;

   always_comb begin
      dims_in = dims_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dmm_pkg::CSR_ROWS_A:    dims_in.rows_a    = csr_wdata;
            dmm_pkg::CSR_INNER_LEN: dims_in.inner_len = csr_wdata;
            dmm_pkg::CSR_COLS_B:    dims_in.cols_b    = csr_wdata;
            default:                dims_in = dims_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.rows_a    <= dmm_pkg::DIM_RESET;
         dims_ff.inner_len <= dmm_pkg::DIM_RESET;
         dims_ff.cols_b    <= dmm_pkg::DIM_RESET;
      end else begin
         dims_ff <= dims_in;
      end
   end

   dmm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .dims      (dims_ff),
      .rsp_free  (!rsp_valid_ff || !rsp_stall),
      .rsp_ctl   (rsp_ctl),
      .dp_ctl    (dp_ctl),
      .wr_addr   (wr_addr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b)
   );

   dmm_store #(
      .DATA_W (DATA_W),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .dp_ctl    (dp_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (req_data.elem_value[DATA_W-1:0]),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .a_rd_ff   (a_rd),
      .b_rd_ff   (b_rd)
   );

   dmm_mac #(
      .DATA_W (DATA_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .dp_ctl (dp_ctl),
      .a_rd   (a_rd),
      .b_rd   (b_rd),
      .acc_ff (acc)
   );

   assign sum_out = dmm_pkg::SUM_W'(acc);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_ctl.load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ctl.load) begin
         rsp_data_ff.dot_sum     <= sum_out;
         rsp_data_ff.index_error <= rsp_ctl.index_error;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/dmm_checker.sv =====
`default_nettype none

module dmm_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_stall,
   input dmm_pkg::req_type                 req_data,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input dmm_pkg::rsp_type                 rsp_data,
   input wire                              csr_valid,
   input wire                              csr_ready,
   input wire [dmm_pkg::CSR_IDX_W-1:0]     csr_index,
   input wire [dmm_pkg::DIM_CFG_W-1:0]     csr_wdata
);

   logic item_in;

   assign item_in = req_valid && !req_stall &&
                    (req_data.cmd == dmm_pkg::CMD_WRITE_A ||
                     req_data.cmd == dmm_pkg::CMD_WRITE_B ||
                     req_data.cmd == dmm_pkg::CMD_COMPUTE);

   // No result may be pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A held result keeps its payload until the transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Items are worked one at a time: an accepted item blocks the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      item_in |=> req_stall)
      else $error("item accepted while busy");

   // A new result only appears after the block has been busy with an item.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work");

   // Write transfers are never refused on the register port.
   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind dense_matrix_multiply_core dmm_checker u_dmm_checker (.*);

`default_nettype wire

// ===== sim/dense_matrix_multiply_core_tb.sv =====
module dense_matrix_multiply_core_tb;

   localparam int MAX_DIM = 16;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int DRAIN_CYCLES = 32;
   localparam int RANDOM_ITEMS = 1200;
   localparam int PHASES = 6;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   dmm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   dmm_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [dmm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [dmm_pkg::DIM_CFG_W-1:0] csr_wdata = '0;

   // Mirror of the block, updated on every accepted transfer.
   logic [dmm_pkg::VALUE_W-1:0] a_elems [STORE_DEPTH];
   logic [dmm_pkg::VALUE_W-1:0] b_elems [STORE_DEPTH];
   logic [dmm_pkg::DIM_CFG_W-1:0] rows_cfg = dmm_pkg::DIM_RESET;
   logic [dmm_pkg::DIM_CFG_W-1:0] inner_cfg = dmm_pkg::DIM_RESET;
   logic [dmm_pkg::DIM_CFG_W-1:0] cols_cfg = dmm_pkg::DIM_RESET;
   dmm_pkg::rsp_type pending_c[$];
   int errors = 0;

   // Stimulus bookkeeping, kept apart from the mirror so that it never races
   // with the monitor at an accept edge.
   bit a_filled [STORE_DEPTH];
   bit b_filled [STORE_DEPTH];
   int plan_m = MAX_DIM;
   int plan_k = MAX_DIM;
   int plan_n = MAX_DIM;
   bit steady = 1'b0;
   int rsp_hold = 0;

   dense_matrix_multiply_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_dim(input logic [dmm_pkg::DIM_CFG_W-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : int'(v);
   endfunction

   // Applies one item to the mirrored stores and returns whether it yields a result.
   function automatic bit matmul_outcome(input dmm_pkg::req_type r,
                                         output dmm_pkg::rsp_type c);
      int m, kd, n, k;
      logic [dmm_pkg::SUM_W-1:0] acc;
      bit produced;
      m = clamp_dim(rows_cfg);
      kd = clamp_dim(inner_cfg);
      n = clamp_dim(cols_cfg);
      acc = '0;
      c = '0;
      produced = 1'b1;
      case (r.cmd)
         dmm_pkg::CMD_WRITE_A: begin
            c.index_error = !(r.row_idx < m && r.col_idx < kd);
            if (!c.index_error) a_elems[r.row_idx * MAX_DIM + r.col_idx] = r.elem_value;
         end
         dmm_pkg::CMD_WRITE_B: begin
            c.index_error = !(r.row_idx < kd && r.col_idx < n);
            if (!c.index_error) b_elems[r.row_idx * MAX_DIM + r.col_idx] = r.elem_value;
         end
         dmm_pkg::CMD_COMPUTE: begin
            c.index_error = !(r.row_idx < m && r.col_idx < n);
            if (!c.index_error) begin
               for (k = 0; k < kd; k++) begin
                  acc += a_elems[r.row_idx * MAX_DIM + k] * b_elems[k * MAX_DIM + r.col_idx];
               end
            end
            c.dot_sum = acc;
         end
         default: produced = 1'b0;
      endcase
      return produced;
   endfunction

   always @(posedge clock) begin : monitor
      dmm_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_c.size() == 0) begin
               $error("result transfer with nothing outstanding: dot_sum %0d index_error %0b",
                      rsp_data.dot_sum, rsp_data.index_error);
               errors++;
            end else begin
               want = pending_c.pop_front();
               if (rsp_data.dot_sum !== want.dot_sum) begin
                  $error("dot_sum: expected %0d, actual %0d", want.dot_sum, rsp_data.dot_sum);
                  errors++;
               end
               if (rsp_data.index_error !== want.index_error) begin
                  $error("index_error: expected %0b, actual %0b",
                         want.index_error, rsp_data.index_error);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dmm_pkg::CSR_ROWS_A:    rows_cfg = csr_wdata;
               dmm_pkg::CSR_INNER_LEN: inner_cfg = csr_wdata;
               dmm_pkg::CSR_COLS_B:    cols_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (matmul_outcome(req_data, want)) pending_c.push_back(want);
         end
      end
   end

   // After each result transfer the receiver draws how long it holds off.
   always @(posedge clock) begin : rsp_pacing
      int n;
      if (rsp_valid && !rsp_stall) begin
         n = steady ? 0 : $urandom_range(0, 7);
         rsp_stall <= (n != 0);
         rsp_hold <= n;
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_hold <= 0;
         rsp_stall <= 1'b0;
      end
   end

   function automatic dmm_pkg::req_type make_req(input logic [1:0] code, input int row,
                                                 input int col,
                                                 input logic [dmm_pkg::VALUE_W-1:0] value);
      dmm_pkg::req_type r;
      r.cmd = dmm_pkg::cmd_type'(code);
      r.row_idx = dmm_pkg::IDX_IN_W'(row);
      r.col_idx = dmm_pkg::IDX_IN_W'(col);
      r.elem_value = value;
      return r;
   endfunction

   function automatic logic [dmm_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(0, 11))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         4: return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   function automatic int draw_index(input int dim);
      return (dim == 0) ? $urandom_range(0, MAX_DIM - 1) : $urandom_range(0, dim - 1);
   endfunction

   function automatic logic [dmm_pkg::DIM_CFG_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return dmm_pkg::DIM_CFG_W'($urandom_range(17, 31));
         default: return dmm_pkg::DIM_CFG_W'($urandom_range(1, MAX_DIM));
      endcase
   endfunction

   // Leaves req_valid high after the transfer so that a following item can go
   // out back to back.
   task automatic send_item(input dmm_pkg::req_type r);
      int gap, addr;
      gap = steady ? 0 : $urandom_range(0, 7);
      addr = r.row_idx * MAX_DIM + r.col_idx;
      if (r.cmd == dmm_pkg::CMD_WRITE_A && r.row_idx < plan_m && r.col_idx < plan_k)
         a_filled[addr] = 1'b1;
      if (r.cmd == dmm_pkg::CMD_WRITE_B && r.row_idx < plan_k && r.col_idx < plan_n)
         b_filled[addr] = 1'b1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // An unused command gives no result, so the wait goes on for DRAIN_CYCLES once the
   // last result is in.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_c.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_dims(input logic [dmm_pkg::DIM_CFG_W-1:0] m,
                           input logic [dmm_pkg::DIM_CFG_W-1:0] k,
                           input logic [dmm_pkg::DIM_CFG_W-1:0] n);
      logic [dmm_pkg::CSR_IDX_W-1:0] idx [3] =
         '{dmm_pkg::CSR_ROWS_A, dmm_pkg::CSR_INNER_LEN, dmm_pkg::CSR_COLS_B};
      logic [dmm_pkg::DIM_CFG_W-1:0] vals [3];
      int i;
      vals[0] = m;
      vals[1] = k;
      vals[2] = n;
      drain_results();
      for (i = 0; i < 3; i++) begin
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      plan_m = clamp_dim(m);
      plan_k = clamp_dim(k);
      plan_n = clamp_dim(n);
   endtask

   task automatic test_store_extremes();
      send_item(make_req(dmm_pkg::CMD_WRITE_A, 15, 15, 32'h7fff_ffff));
      send_item(make_req(dmm_pkg::CMD_WRITE_B, 15, 15, 32'h8000_0000));
      send_item(make_req(dmm_pkg::CMD_WRITE_A, 0, 0, 32'hffff_ffff));
      send_item(make_req(dmm_pkg::CMD_WRITE_B, 0, 0, 32'hffff_ffff));
      send_item(make_req(dmm_pkg::CMD_WRITE_A, 15, 0, 32'h8000_0000));
      send_item(make_req(dmm_pkg::CMD_WRITE_B, 0, 15, 32'hffff_ffff));
      send_item(make_req(CMD_UNUSED, 15, 15, 32'hffff_ffff));
      send_item(make_req(CMD_UNUSED, 0, 0, 32'h0000_0000));
   endtask

   task automatic test_unit_dims();
      set_dims(5'd1, 5'd1, 5'd1);
      send_item(make_req(dmm_pkg::CMD_COMPUTE, 0, 0, 32'h0));
      send_item(make_req(dmm_pkg::CMD_COMPUTE, 0, 1, 32'h0));
      send_item(make_req(dmm_pkg::CMD_COMPUTE, 1, 0, 32'h0));
      send_item(make_req(dmm_pkg::CMD_COMPUTE, 15, 15, 32'h0));
      send_item(make_req(dmm_pkg::CMD_WRITE_A, 0, 1, 32'h1));
      send_item(make_req(dmm_pkg::CMD_WRITE_B, 1, 0, 32'h1));
      send_item(make_req(dmm_pkg::CMD_WRITE_A, 1, 0, 32'h1));
   endtask

   // With no shared dimension a compute inside the result bounds is an empty sum.
   task automatic test_empty_inner();
      set_dims(5'd1, 5'd0, 5'd1);
      send_item(make_req(dmm_pkg::CMD_COMPUTE, 0, 0, 32'h0));
      send_item(make_req(dmm_pkg::CMD_WRITE_A, 0, 0, 32'h5));
      send_item(make_req(dmm_pkg::CMD_WRITE_B, 0, 0, 32'h5));
   endtask

   task automatic test_zero_outer();
      set_dims(5'd0, 5'd1, 5'd0);
      send_item(make_req(dmm_pkg::CMD_COMPUTE, 0, 0, 32'h0));
      send_item(make_req(dmm_pkg::CMD_WRITE_A, 0, 0, 32'h7));
      send_item(make_req(dmm_pkg::CMD_WRITE_B, 0, 0, 32'h7));
   endtask

   // Register values above the store size behave as the full size.
   task automatic test_saturated_dims();
      set_dims(5'd31, 5'd31, 5'd17);
      send_item(make_req(dmm_pkg::CMD_WRITE_A, 15, 15, 32'h7fff_ffff));
      send_item(make_req(dmm_pkg::CMD_WRITE_B, 15, 15, 32'h8000_0000));
      set_dims(5'd31, 5'd1, 5'd31);
      send_item(make_req(dmm_pkg::CMD_COMPUTE, 15, 15, 32'h0));
      send_item(make_req(dmm_pkg::CMD_COMPUTE, 0, 0, 32'h0));
      send_item(make_req(dmm_pkg::CMD_COMPUTE, 15, 0, 32'h0));
      send_item(make_req(dmm_pkg::CMD_COMPUTE, 0, 15, 32'h0));
   endtask

   task automatic test_random_traffic();
      int phase, sent, pick, row, col, k;
      logic [1:0] code;
      dmm_pkg::req_type r;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_dims(5'd16, 5'd16, 5'd16);
            1: set_dims(5'd2, 5'd16, 5'd2);
            default: set_dims(pick_dim(), pick_dim(), pick_dim());
         endcase
         steady = (phase == 2);
         sent = 0;
         while (sent < RANDOM_ITEMS / PHASES) begin
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
               code = (pick < 30) ? dmm_pkg::CMD_WRITE_A :
                      (pick < 60) ? dmm_pkg::CMD_WRITE_B : dmm_pkg::CMD_COMPUTE;
               row = draw_index((code == dmm_pkg::CMD_WRITE_B) ? plan_k : plan_m);
               col = draw_index((code == dmm_pkg::CMD_WRITE_A) ? plan_k : plan_n);
            end else begin
               code = 2'($urandom_range(0, 3));
               row = $urandom_range(0, MAX_DIM - 1);
               col = $urandom_range(0, MAX_DIM - 1);
            end
            r = make_req(code, row, col, random_value());
            // A compute is only issued once its whole row of A and column of B
            // hold data; until then the lowest missing element is written instead.
            if (code == dmm_pkg::CMD_COMPUTE && row < plan_m && col < plan_n) begin
               for (k = plan_k - 1; k >= 0; k--) begin
                  if (!b_filled[k * MAX_DIM + col])
                     r = make_req(dmm_pkg::CMD_WRITE_B, k, col, random_value());
                  if (!a_filled[row * MAX_DIM + k])
                     r = make_req(dmm_pkg::CMD_WRITE_A, row, k, random_value());
               end
            end
            send_item(r);
            if (r.cmd != CMD_UNUSED) sent++;
            if ($urandom_range(0, 99) == 0) drain_results();
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_store_extremes();
      test_unit_dims();
      test_empty_inner();
      test_zero_outer();
      test_saturated_dims();
      test_random_traffic();
      drain_results();
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
design/dmm_pkg.sv
design/dmm_store.sv
design/dmm_mac.sv
design/dmm_ctrl.sv
design/dense_matrix_multiply_core.sv
design/dmm_checker.sv
sim/dense_matrix_multiply_core_tb.sv
